### rtl/core/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HEADER_W  = 16;
    localparam int unsigned LENGTH_W  = 24;
    localparam int unsigned CMD_W     = 16;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LENGTH = 1'd1;

    localparam logic [HEADER_W-1:0] HEADER_WORD_RESET      = 16'hFEFF;
    localparam logic [LENGTH_W-1:0] MAX_FRAME_LENGTH_RESET = 24'd65535;

    // The length field exceeds the payload byte count by four.
    localparam logic [LENGTH_W-1:0] LENGTH_OVERHEAD = 24'd4;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GOOD         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUM_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH_RANGE = 2'd2;

    localparam logic [1:0] IDX_FIRST = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD = 2'd2;
    localparam logic [1:0] IDX_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_LENGTH,
        PH_CMD,
        PH_PAYLOAD,
        PH_SUMLO,
        PH_SUMHI
    } phase_t;

    typedef struct packed {
        logic [HEADER_W-1:0] header_word;
        logic [LENGTH_W-1:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic                out_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [CMD_W-1:0]    command_code;
        logic [STATUS_W-1:0] frame_status;
        logic [LENGTH_W-1:0] payload_count;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/lfpd_ifs.sv
`default_nettype none

interface lfpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfpd_result_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [15:0] command_code;
    logic [1:0]  frame_status;
    logic [23:0] payload_count;

    modport source (
        output valid, output out_kind, output payload_byte, output command_code,
        output frame_status, output payload_count, input ready
    );
    modport sink (
        input valid, input out_kind, input payload_byte, input command_code,
        input frame_status, input payload_count, output ready
    );
endinterface

`default_nettype wire

### rtl/core/lfpd_parser.sv
`default_nettype none

module lfpd_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [lfpd_pkg::BYTE_W-1:0] rx_byte,
    input  wire lfpd_pkg::cfg_t              cfg,
    output logic                             res_valid,
    output lfpd_pkg::result_t                res
);

    lfpd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]                      idx_reg, idx_next;
    logic [lfpd_pkg::LENGTH_W-1:0]   len_reg, len_next;
    logic [lfpd_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [lfpd_pkg::LENGTH_W-1:0]   remaining_reg, remaining_next;
    logic [lfpd_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [lfpd_pkg::BYTE_W-1:0]     sum_lo_reg, sum_lo_next;

    logic [lfpd_pkg::BYTE_W-1:0]     sync_lo;
    logic [lfpd_pkg::BYTE_W-1:0]     sync_hi;
    logic                            length_bad;
    logic [lfpd_pkg::LENGTH_W-1:0]   length_net;
    logic [lfpd_pkg::LENGTH_W-1:0]   remaining_dec;
    logic                            sum_match;

    assign sync_lo = cfg.header_word[7:0];
    assign sync_hi = cfg.header_word[15:8];

    // Only the lower three length bytes are kept; a non-zero top byte is
    // always beyond the largest allowed length.
    assign length_bad = (rx_byte != '0) || (len_reg < lfpd_pkg::LENGTH_OVERHEAD)
                        || (len_reg > cfg.max_frame_length);
    assign length_net    = len_reg - lfpd_pkg::LENGTH_OVERHEAD;
    assign remaining_dec = remaining_reg - 24'd1;
    assign sum_match     = ({rx_byte, sum_lo_reg} == sum_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                lfpd_pkg::PH_HUNT0:
                begin
                    if (rx_byte == sync_lo)
                        phase_next = lfpd_pkg::PH_HUNT1;
                end
                lfpd_pkg::PH_HUNT1:
                begin
                    if (rx_byte == sync_hi)
                        phase_next = lfpd_pkg::PH_LENGTH;
                    else if (rx_byte != sync_lo)
                        phase_next = lfpd_pkg::PH_HUNT0;
                end
                lfpd_pkg::PH_LENGTH:
                begin
                    if (idx_reg == lfpd_pkg::IDX_LAST)
                        phase_next = length_bad ? lfpd_pkg::PH_HUNT0 : lfpd_pkg::PH_CMD;
                end
                lfpd_pkg::PH_CMD:
                begin
                    if (idx_reg == lfpd_pkg::IDX_SECOND)
                        phase_next = (remaining_reg == '0) ? lfpd_pkg::PH_SUMLO
                                                           : lfpd_pkg::PH_PAYLOAD;
                end
                lfpd_pkg::PH_PAYLOAD:
                begin
                    if (remaining_dec == '0)
                        phase_next = lfpd_pkg::PH_SUMLO;
                end
                lfpd_pkg::PH_SUMLO:
                    phase_next = lfpd_pkg::PH_SUMHI;
                lfpd_pkg::PH_SUMHI:
                    phase_next = lfpd_pkg::PH_HUNT0;
                default:
                    phase_next = lfpd_pkg::PH_HUNT0;
            endcase
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        len_next       = len_reg;
        cmd_next       = cmd_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        sum_lo_next    = sum_lo_reg;
        res_valid      = 1'b0;
        res            = '0;
        if (accept)
        begin
            unique case (phase_reg)
                lfpd_pkg::PH_HUNT0:
                begin
                end
                lfpd_pkg::PH_HUNT1:
                begin
                    if (rx_byte == sync_hi)
                    begin
                        idx_next = lfpd_pkg::IDX_FIRST;
                        sum_next = '0;
                    end
                end
                lfpd_pkg::PH_LENGTH:
                begin
                    idx_next = idx_reg + 2'd1;
                    case (idx_reg)
                        lfpd_pkg::IDX_FIRST:  len_next[7:0]   = rx_byte;
                        lfpd_pkg::IDX_SECOND: len_next[15:8]  = rx_byte;
                        lfpd_pkg::IDX_THIRD:  len_next[23:16] = rx_byte;
                        default:
                        begin
                            idx_next       = lfpd_pkg::IDX_FIRST;
                            remaining_next = length_net;
                            if (length_bad)
                            begin
                                res_valid         = 1'b1;
                                res.out_kind      = lfpd_pkg::KIND_FRAME_END;
                                res.frame_status  = lfpd_pkg::STATUS_LENGTH_RANGE;
                            end
                        end
                    endcase
                end
                lfpd_pkg::PH_CMD:
                begin
                    if (idx_reg == lfpd_pkg::IDX_FIRST)
                    begin
                        cmd_next[7:0] = rx_byte;
                        idx_next      = lfpd_pkg::IDX_SECOND;
                    end
                    else
                    begin
                        cmd_next[15:8] = rx_byte;
                        idx_next       = lfpd_pkg::IDX_FIRST;
                    end
                end
                lfpd_pkg::PH_PAYLOAD:
                begin
                    sum_next         = sum_reg + lfpd_pkg::SUM_W'(rx_byte);
                    remaining_next   = remaining_dec;
                    res_valid        = 1'b1;
                    res.out_kind     = lfpd_pkg::KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.command_code = cmd_reg;
                end
                lfpd_pkg::PH_SUMLO:
                    sum_lo_next = rx_byte;
                lfpd_pkg::PH_SUMHI:
                begin
                    res_valid         = 1'b1;
                    res.out_kind      = lfpd_pkg::KIND_FRAME_END;
                    res.command_code  = cmd_reg;
                    res.frame_status  = sum_match ? lfpd_pkg::STATUS_GOOD
                                                  : lfpd_pkg::STATUS_SUM_MISMATCH;
                    res.payload_count = length_net;
                    sum_next          = '0;
                end
                default:
                begin
                    idx_next = lfpd_pkg::IDX_FIRST;
                    sum_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lfpd_pkg::PH_HUNT0;
            idx_reg       <= lfpd_pkg::IDX_FIRST;
            len_reg       <= '0;
            cmd_reg       <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            sum_lo_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            cmd_reg       <= cmd_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            sum_lo_reg    <= sum_lo_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lfpd_out_buf.sv
`default_nettype none

module lfpd_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire lfpd_pkg::result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output lfpd_pkg::result_t      out_data,
    input  wire logic              out_ready
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    lfpd_pkg::result_t main_reg, main_next;
    lfpd_pkg::result_t skid_reg, skid_next;

    // The skid stage catches the transfer that arrives in the cycle the
    // receiver stalls, so ready upstream comes straight from a register.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### rtl/core/length_framed_packet_deframer_core.sv
// Length-framed packet deframer.
// Bytes of the received stream enter on the bytes channel, one per transfer.
// The block hunts for the sync word, reads a little-endian length and command,
// passes each payload byte to the results channel as it arrives and closes
// each frame with a frame-end result carrying the command, a status (good or
// sum mismatch) and the payload byte count, or with a length out of range
// status alone. A byte is taken in every cycle while the output has room:
// throughput is one byte per cycle, and each result is registered in a
// two-entry output stage. The field state machine and the 16-bit sum update
// in the cycle of the transfer. When the receiver stalls, the output stage
// fills and bytes ready falls once its skid entry is taken; nothing is lost.
// Reset loads the register defaults (sync word 0xFEFF, largest length 65535),
// empties the output stage and restarts the hunt. The write port takes
// header_word at index 0 and max_frame_length at index 1; the user must use it
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module length_framed_packet_deframer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lfpd_byte_if.sink                           bytes,
    lfpd_result_if.source                       results,
    input  wire logic                           cfg_we,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lfpd_pkg::LENGTH_W-1:0]  cfg_data
);

    lfpd_pkg::cfg_t    cfg_reg;
    logic              accept;
    logic              res_valid;
    lfpd_pkg::result_t res;
    logic              buf_ready;
    lfpd_pkg::result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word      <= lfpd_pkg::HEADER_WORD_RESET;
            cfg_reg.max_frame_length <= lfpd_pkg::MAX_FRAME_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfpd_pkg::REG_HEADER_WORD:
                    cfg_reg.header_word <= cfg_data[lfpd_pkg::HEADER_W-1:0];
                lfpd_pkg::REG_MAX_FRAME_LENGTH:
                    cfg_reg.max_frame_length <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign bytes.ready = buf_ready;
    assign accept      = bytes.valid && buf_ready;

    lfpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (bytes.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lfpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (buf_ready),
        .out_valid (results.valid),
        .out_data  (out_data),
        .out_ready (results.ready)
    );

    assign results.out_kind      = out_data.out_kind;
    assign results.payload_byte  = out_data.payload_byte;
    assign results.command_code  = out_data.command_code;
    assign results.frame_status  = out_data.frame_status;
    assign results.payload_count = out_data.payload_count;

endmodule

`default_nettype wire

### tb/length_framed_packet_deframer_core_test.sv
`timescale 1ns / 100ps

module length_framed_packet_deframer_core_test;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lfpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lfpd_pkg::LENGTH_W-1:0]  cfg_data;

    lfpd_byte_if   byte_ch ();
    lfpd_result_if result_ch ();

    length_framed_packet_deframer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Deframer state as the testbench tracks it.
    logic [lfpd_pkg::HEADER_W-1:0] sync_word;
    logic [lfpd_pkg::LENGTH_W-1:0] length_limit;
    lfpd_pkg::phase_t              frame_phase;
    logic [1:0]                    field_idx;
    logic [31:0]                   length_acc;
    logic [lfpd_pkg::CMD_W-1:0]    cmd_acc;
    logic [lfpd_pkg::LENGTH_W-1:0] bytes_left;
    logic [lfpd_pkg::SUM_W-1:0]    byte_sum;
    logic [lfpd_pkg::BYTE_W-1:0]   sum_lo;

    lfpd_pkg::result_t expected_results[$];
    int unsigned mismatches    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned quiet_cycles  = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic lfpd_pkg::result_t make_result(input logic kind,
                                                      input logic [7:0] pbyte,
                                                      input logic [15:0] cmd,
                                                      input logic [1:0] status,
                                                      input logic [23:0] count);
        lfpd_pkg::result_t r;
        r.out_kind      = kind;
        r.payload_byte  = pbyte;
        r.command_code  = cmd;
        r.frame_status  = status;
        r.payload_count = count;
        return r;
    endfunction

    task automatic reset_frame_fields();
        field_idx  = lfpd_pkg::IDX_FIRST;
        length_acc = '0;
        cmd_acc    = '0;
        bytes_left = '0;
        byte_sum   = '0;
        sum_lo     = '0;
    endtask

    // Advances the tracked deframer by one accepted byte and queues any result it causes.
    task automatic predict_byte(input logic [7:0] b);
        case (frame_phase)
            lfpd_pkg::PH_HUNT0:
            begin
                if (b == sync_word[7:0])
                    frame_phase = lfpd_pkg::PH_HUNT1;
            end
            lfpd_pkg::PH_HUNT1:
            begin
                if (b == sync_word[15:8])
                begin
                    reset_frame_fields();
                    frame_phase = lfpd_pkg::PH_LENGTH;
                end
                else if (b != sync_word[7:0])
                    frame_phase = lfpd_pkg::PH_HUNT0;
            end
            lfpd_pkg::PH_LENGTH:
            begin
                length_acc[8*field_idx +: 8] = b;
                if (field_idx != lfpd_pkg::IDX_LAST)
                    field_idx++;
                else
                begin
                    field_idx = lfpd_pkg::IDX_FIRST;
                    if (length_acc < 32'(lfpd_pkg::LENGTH_OVERHEAD) ||
                        length_acc > {8'd0, length_limit})
                    begin
                        expected_results.push_back(make_result(lfpd_pkg::KIND_FRAME_END,
                            8'd0, 16'd0, lfpd_pkg::STATUS_LENGTH_RANGE, 24'd0));
                        frame_phase = lfpd_pkg::PH_HUNT0;
                        reset_frame_fields();
                    end
                    else
                    begin
                        bytes_left  = length_acc[lfpd_pkg::LENGTH_W-1:0]
                                      - lfpd_pkg::LENGTH_OVERHEAD;
                        frame_phase = lfpd_pkg::PH_CMD;
                    end
                end
            end
            lfpd_pkg::PH_CMD:
            begin
                cmd_acc[8*field_idx[0] +: 8] = b;
                if (field_idx == lfpd_pkg::IDX_FIRST)
                    field_idx = lfpd_pkg::IDX_SECOND;
                else
                begin
                    field_idx   = lfpd_pkg::IDX_FIRST;
                    frame_phase = (bytes_left == 0) ? lfpd_pkg::PH_SUMLO
                                                    : lfpd_pkg::PH_PAYLOAD;
                end
            end
            lfpd_pkg::PH_PAYLOAD:
            begin
                byte_sum   = byte_sum + b;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0)
                    frame_phase = lfpd_pkg::PH_SUMLO;
                expected_results.push_back(make_result(lfpd_pkg::KIND_PAYLOAD, b, cmd_acc,
                                                       lfpd_pkg::STATUS_GOOD, 24'd0));
            end
            lfpd_pkg::PH_SUMLO:
            begin
                sum_lo      = b;
                frame_phase = lfpd_pkg::PH_SUMHI;
            end
            lfpd_pkg::PH_SUMHI:
            begin
                expected_results.push_back(make_result(lfpd_pkg::KIND_FRAME_END, 8'd0, cmd_acc,
                    ({b, sum_lo} == byte_sum) ? lfpd_pkg::STATUS_GOOD
                                              : lfpd_pkg::STATUS_SUM_MISMATCH,
                    length_acc[lfpd_pkg::LENGTH_W-1:0] - lfpd_pkg::LENGTH_OVERHEAD));
                frame_phase = lfpd_pkg::PH_HUNT0;
                reset_frame_fields();
            end
            default:
            begin
                frame_phase = lfpd_pkg::PH_HUNT0;
                reset_frame_fields();
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Lowers valid, then waits until every expected result has been seen.
    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lfpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfpd_pkg::LENGTH_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == lfpd_pkg::REG_HEADER_WORD)
            sync_word = data[lfpd_pkg::HEADER_W-1:0];
        else if (idx == lfpd_pkg::REG_MAX_FRAME_LENGTH)
            length_limit = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_le(input logic [31:0] v, input int unsigned nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(v[8*i +: 8]);
    endtask

    task automatic send_sync();
        send_byte(sync_word[7:0]);
        send_byte(sync_word[15:8]);
    endtask

    // A fill below zero gives random payload bytes.
    task automatic send_frame(input logic [15:0] cmd, input int unsigned n, input bit bad_sum,
                              input int fill);
        logic [15:0] s;
        logic [7:0]  b;
        s = '0;
        send_sync();
        send_le(n + 4, 4);
        send_le({16'd0, cmd}, 2);
        for (int unsigned i = 0; i < n; i++)
        begin
            b = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
            s = s + b;
            send_byte(b);
        end
        if (bad_sum)
            s = s ^ 16'($urandom_range(1, 65535));
        send_le({16'd0, s}, 2);
    endtask

    task automatic send_bad_length(input logic [31:0] len);
        send_sync();
        send_le(len, 4);
    endtask

    // A byte that can never start a sync word.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == sync_word[7:0])
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_broken_sync();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == sync_word[7:0] || b == sync_word[15:8])
            b = 8'($urandom_range(255));
        send_byte(sync_word[7:0]);
        send_byte(b);
    endtask

    function automatic int unsigned pick_payload_len();
        int unsigned room;
        int unsigned r;
        int unsigned n;
        room = 32'(length_limit - lfpd_pkg::LENGTH_OVERHEAD);
        r    = $urandom_range(99);
        if (r < 85)
            n = $urandom_range(0, 12);
        else if (r < 97)
            n = $urandom_range(13, 60);
        else
            n = (room <= 200) ? room : $urandom_range(61, 200);
        return (n > room) ? room : n;
    endfunction

    function automatic logic [31:0] pick_bad_length();
        case ($urandom_range(2))
            0:       return 32'($urandom_range(0, 3));
            1:       return {8'd0, length_limit} + 32'd1;
            default: return $urandom | 32'h0100_0000;
        endcase
    endfunction

    task automatic test_default_header();
        send_frame(16'h0000, 3, 1'b0, -1);
        send_frame(16'hFFFF, 0, 1'b0, -1);
        send_frame(16'h1234, 0, 1'b1, -1);
        send_frame(16'hA5A5, 2, 1'b1, -1);
        send_frame(16'h00FF, 3, 1'b0, 0);
        // Enough 0xFF bytes to wrap the 16-bit sum.
        send_frame(16'hFF00, 260, 1'b0, 255);
        wait_idle();
    endtask

    task automatic test_sync_hunt();
        send_byte(noise_byte());
        send_byte(sync_word[7:0]);
        send_byte(sync_word[7:0]);
        send_frame(16'h5A5A, 2, 1'b0, -1);
        send_broken_sync();
        send_frame(16'hC3C3, 1, 1'b0, -1);
        wait_idle();
    endtask

    task automatic test_length_range();
        send_bad_length(32'd0);
        send_bad_length(32'd3);
        send_bad_length(32'd65536);
        send_bad_length(32'hFFFF_FFFF);
        wait_idle();
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, 24'd4);
        send_frame(16'h0004, 0, 1'b0, -1);
        send_bad_length(32'd5);
        wait_idle();
        // Below four, even the shortest frame is rejected.
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, 24'd3);
        send_bad_length(32'd4);
        send_bad_length(32'd3);
        wait_idle();
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, 24'hFF_FFFF);
        send_bad_length(32'h0100_0000);
        send_frame(16'h7E7E, 5, 1'b0, -1);
        wait_idle();
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, 24'd200);
        send_frame(16'h0C0C, 196, 1'b0, -1);
        send_bad_length(32'd201);
        wait_idle();
    endtask

    task automatic test_header_extremes();
        write_reg(lfpd_pkg::REG_HEADER_WORD, 24'h00_0000);
        send_frame(16'h1111, 2, 1'b0, -1);
        wait_idle();
        // With both halves equal, two low bytes in a row already form the sync word.
        write_reg(lfpd_pkg::REG_HEADER_WORD, 24'h00_FFFF);
        send_frame(16'h2222, 2, 1'b1, -1);
        send_broken_sync();
        send_frame(16'h3333, 1, 1'b0, -1);
        wait_idle();
        write_reg(lfpd_pkg::REG_HEADER_WORD, 24'h00_00FF);
        send_frame(16'h4444, 2, 1'b0, -1);
        wait_idle();
    endtask

    task automatic test_back_pressure();
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, 24'd65535);
        hold_request = HOLD_CYCLES;
        send_frame(16'hBEEF, 40, 1'b0, -1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int unsigned quota, input int unsigned send_pct,
                                       input int unsigned recv_pct, input logic [15:0] header,
                                       input logic [23:0] limit);
        int unsigned target;
        int unsigned r;
        write_reg(lfpd_pkg::REG_HEADER_WORD, {8'd0, header});
        write_reg(lfpd_pkg::REG_MAX_FRAME_LENGTH, limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target        = bytes_sent + quota;
        while (bytes_sent < target)
        begin
            r = $urandom_range(99);
            if (length_limit < lfpd_pkg::LENGTH_OVERHEAD || r < 10)
                send_bad_length(pick_bad_length());
            else if (r < 80)
            begin
                if (sync_word[7:0] != sync_word[15:8] && $urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(sync_word[7:0]);
                send_frame(16'($urandom_range(65535)), pick_payload_len(),
                           $urandom_range(99) < 15, -1);
            end
            else if (r < 90)
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            else
                send_broken_sync();
        end
        wait_idle();
    endtask

    // Receiver side: random stalls, plus a long hold-off on request.
    initial
    begin
        int unsigned n;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                n            = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        lfpd_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte %02h cmd %04h ",
                             result_ch.out_kind, result_ch.payload_byte,
                             result_ch.command_code,
                             "status %0d count %0d",
                             result_ch.frame_status, result_ch.payload_count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.out_kind !== result_ch.out_kind ||
                    want.payload_byte !== result_ch.payload_byte ||
                    want.command_code !== result_ch.command_code ||
                    want.frame_status !== result_ch.frame_status ||
                    want.payload_count !== result_ch.payload_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected kind %0d byte %02h cmd %04h ",
                                 want.out_kind, want.payload_byte, want.command_code,
                                 "status %0d count %0d, ",
                                 want.frame_status, want.payload_count,
                                 "got kind %0d byte %02h cmd %04h ",
                                 result_ch.out_kind, result_ch.payload_byte,
                                 result_ch.command_code,
                                 "status %0d count %0d",
                                 result_ch.frame_status, result_ch.payload_count);
                end
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        sync_word       = lfpd_pkg::HEADER_WORD_RESET;
        length_limit    = lfpd_pkg::MAX_FRAME_LENGTH_RESET;
        frame_phase     = lfpd_pkg::PH_HUNT0;
        reset_frame_fields();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 68;
        test_default_header();
        test_sync_hunt();
        test_length_range();
        test_header_extremes();
        test_back_pressure();
        test_random_traffic(200, 34, 68, 16'($urandom_range(65535)), 24'd65535);
        test_random_traffic(200, 68, 34, 16'($urandom_range(65535)),
                            24'($urandom_range(4, 200)));
        test_random_traffic(200, 0, 0, 16'($urandom_range(65535)), 24'hFF_FFFF);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_ifs.sv
rtl/core/lfpd_parser.sv
rtl/core/lfpd_out_buf.sv
rtl/core/length_framed_packet_deframer_core.sv
tb/length_framed_packet_deframer_core_test.sv
